### rtl/core/text_command_line_parser_assert.svh
// Assertion macros for the command line parser checker.
// Every macro samples on the rising edge of clk and is idle while rst_n is low.
`ifndef TEXT_COMMAND_LINE_PARSER_ASSERT_SVH
`define TEXT_COMMAND_LINE_PARSER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCLP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TCLP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/tclp_pkg.sv
// Package for the text command line parser: widths, character codes,
// command prefixes and command codes. It has no dependencies.
`timescale 1ns / 1ps

package tclp_pkg;

  localparam int LINE_LIMIT  = 256;
  localparam int LEN_W       = $clog2(LINE_LIMIT);
  localparam int PERIOD_BITS = 16;
  localparam int NPAT        = 6;
  localparam int PAT_MAX     = 8;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;

  // Result tdata layout
  localparam int OUT_FAHR_BIT   = 0;
  localparam int OUT_REP_BIT    = 1;
  localparam int OUT_PERIOD_LSB = 2;
  localparam int OUT_SHUT_BIT   = OUT_PERIOD_LSB + PERIOD_BITS;
  localparam int OUT_CODE_LSB   = OUT_SHUT_BIT + 1;
  localparam int CODE_W         = 3;
  localparam int OUT_USED       = OUT_CODE_LSB + CODE_W;
  localparam int OUT_W          = ((OUT_USED + 7) / 8) * 8;

  typedef enum logic [CODE_W-1:0] {
    CMD_NONE   = 3'd0,
    CMD_SCALE  = 3'd1,
    CMD_PERIOD = 3'd2,
    CMD_STOP   = 3'd3,
    CMD_START  = 3'd4,
    CMD_LOG    = 3'd5,
    CMD_OFF    = 3'd6
  } cmd_t;

  typedef enum logic [2:0] {
    PH_SKIP   = 3'b001,
    PH_DIGITS = 3'b010,
    PH_DONE   = 3'b100
  } phase_t;

  localparam logic [CFG_IDX_W-1:0] REG_START_FAHR   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_PERIOD = 2'd1;

  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;
  localparam logic [7:0] CH_C     = 8'd67;
  localparam logic [7:0] CH_F     = 8'd70;

  localparam logic [PERIOD_BITS-1:0] PERIOD_MAX = '1;
  localparam logic [PERIOD_BITS-1:0] PERIOD_RST = PERIOD_BITS'(1);

  // Prefixes in priority order
  localparam logic [7:0] PAT_TEXT [NPAT][PAT_MAX] = '{
    '{8'h53, 8'h43, 8'h41, 8'h4C, 8'h45, 8'h3D, 8'h00, 8'h00},
    '{8'h50, 8'h45, 8'h52, 8'h49, 8'h4F, 8'h44, 8'h3D, 8'h00},
    '{8'h53, 8'h54, 8'h4F, 8'h50, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h53, 8'h54, 8'h41, 8'h52, 8'h54, 8'h00, 8'h00, 8'h00},
    '{8'h4C, 8'h4F, 8'h47, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h4F, 8'h46, 8'h46, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };
  localparam logic [2:0] PAT_LEN [NPAT] = '{3'd6, 3'd7, 3'd4, 3'd5, 3'd3, 3'd3};
  localparam cmd_t PAT_CODE [NPAT] = '{CMD_SCALE, CMD_PERIOD, CMD_STOP,
                                       CMD_START, CMD_LOG, CMD_OFF};

  localparam logic [2:0] SCALE_POS  = 3'd6;
  localparam logic [2:0] NUMBER_POS = 3'd7;

endpackage

### rtl/core/text_command_line_parser.sv
// Text command line parser top level: byte stream in, mode/period/command out.
// Depends on tclp_pkg.
`timescale 1ns / 1ps

//  channel | direction | payload
//  in_     | slave     | tdata[7:0] rx_byte
//  out_    | master    | tdata mode, period, command; tlast line_end
//  cfg_    | write     | index 0 start_fahrenheit, 1 start_period
//
// One item per cycle when not stalled; each byte yields one registered item.
// The line state and accumulator update in the cycle a byte is taken.
// Synchronous active-low reset; no clearing pass.
// A stalled result holds in the output register; a new byte is taken in the
// cycle the held item leaves.

module text_command_line_parser
  import tclp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,   // [7:0] rx_byte
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [OUT_W-1:0]     out_tdata,  // fahrenheit, reporting, period_seconds,
                                           // shut_down, command_code, zero pad
  output logic                 out_tlast,  // line_end
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic [LEN_W-1:0]       len_r, len_nxt;
  logic [NPAT-1:0]        alive_r, alive_nxt;
  logic [7:0]             letter_r, letter_nxt;
  phase_t                 phase_r, phase_nxt;
  logic                   neg_r, neg_nxt;
  logic [PERIOD_BITS-1:0] accum_r, accum_nxt;
  logic                   fahr_r, fahr_nxt;
  logic                   rep_r, rep_nxt;
  logic                   shut_r, shut_nxt;
  logic [PERIOD_BITS-1:0] period_r, period_nxt;
  logic                   ended;
  cmd_t                   code;

  logic                   out_valid_r;
  logic [OUT_W-1:0]       out_data_r;
  logic                   out_last_r;

  logic                   in_fire;
  logic [7:0]             b;
  logic                   stored, is_digit, is_space;
  logic [PERIOD_BITS+3:0] prod;

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign b         = in_tdata;

  assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
  assign is_space = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
  assign prod     = {4'b0, accum_r} * (PERIOD_BITS+4)'(10)
                  + (PERIOD_BITS+4)'(b - CH_ZERO);
  assign stored   = (b != 8'd0) && (len_r < LEN_W'(LINE_LIMIT - 2));

  always_comb begin
    len_nxt    = len_r;
    alive_nxt  = alive_r;
    letter_nxt = letter_r;
    phase_nxt  = phase_r;
    neg_nxt    = neg_r;
    accum_nxt  = accum_r;
    fahr_nxt   = fahr_r;
    rep_nxt    = rep_r;
    shut_nxt   = shut_r;
    period_nxt = period_r;
    ended      = 1'b0;
    code       = CMD_NONE;

    if (stored) begin
      for (int k = 0; k < NPAT; k++) begin
        if ((len_r < LEN_W'(PAT_LEN[k])) && (b != PAT_TEXT[k][len_r[2:0]])) begin
          alive_nxt[k] = 1'b0;
        end
      end
      if (len_r == LEN_W'(SCALE_POS)) begin
        letter_nxt = b;
      end
      if (len_r >= LEN_W'(NUMBER_POS)) begin
        unique case (phase_r)
          PH_SKIP: begin
            if (is_space) begin
              phase_nxt = PH_SKIP;
            end else if ((b == CH_PLUS) || (b == CH_MINUS)) begin
              neg_nxt   = (b == CH_MINUS);
              phase_nxt = PH_DIGITS;
            end else if (is_digit) begin
              accum_nxt = (prod > (PERIOD_BITS+4)'(PERIOD_MAX)) ? PERIOD_MAX
                                                                : prod[PERIOD_BITS-1:0];
              phase_nxt = PH_DIGITS;
            end else begin
              phase_nxt = PH_DONE;
            end
          end
          PH_DIGITS: begin
            if (is_digit) begin
              accum_nxt = (prod > (PERIOD_BITS+4)'(PERIOD_MAX)) ? PERIOD_MAX
                                                                : prod[PERIOD_BITS-1:0];
            end else begin
              phase_nxt = PH_DONE;
            end
          end
          PH_DONE: phase_nxt = PH_DONE;
          default: phase_nxt = PH_DONE;
        endcase
      end
      len_nxt = len_r + LEN_W'(1);
    end

    if (b == CH_NL) begin
      ended = 1'b1;
      // lowest index wins
      for (int k = NPAT - 1; k >= 0; k--) begin
        if (alive_nxt[k] && (len_nxt >= LEN_W'(PAT_LEN[k]))) begin
          code = PAT_CODE[k];
        end
      end
      case (code)
        CMD_SCALE: begin
          if (letter_nxt == CH_F) begin
            fahr_nxt = 1'b1;
          end else if (letter_nxt == CH_C) begin
            fahr_nxt = 1'b0;
          end
        end
        CMD_PERIOD: period_nxt = neg_nxt ? '0 : accum_nxt;
        CMD_STOP:   rep_nxt    = 1'b0;
        CMD_START:  rep_nxt    = 1'b1;
        CMD_OFF:    shut_nxt   = 1'b1;
        default: ;
      endcase
      len_nxt    = '0;
      alive_nxt  = '1;
      letter_nxt = '0;
      phase_nxt  = PH_SKIP;
      neg_nxt    = 1'b0;
      accum_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r    <= '0;
      alive_r  <= '1;
      letter_r <= '0;
      phase_r  <= PH_SKIP;
      neg_r    <= 1'b0;
      accum_r  <= '0;
      fahr_r   <= 1'b1;
      rep_r    <= 1'b1;
      shut_r   <= 1'b0;
      period_r <= PERIOD_RST;
    end else begin
      if (in_fire) begin
        len_r    <= len_nxt;
        alive_r  <= alive_nxt;
        letter_r <= letter_nxt;
        phase_r  <= phase_nxt;
        neg_r    <= neg_nxt;
        accum_r  <= accum_nxt;
        fahr_r   <= fahr_nxt;
        rep_r    <= rep_nxt;
        shut_r   <= shut_nxt;
        period_r <= period_nxt;
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_START_FAHR:   fahr_r   <= cfg_data[0];
          REG_START_PERIOD: period_r <= PERIOD_BITS'(cfg_data);
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= OUT_W'({code, shut_nxt, period_nxt, rep_nxt, fahr_nxt});
      out_last_r <= ended;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

### rtl/core/tclp_checker.sv
// Port-level checker for text_command_line_parser, bound to the top level.
// Depends on tclp_pkg and text_command_line_parser_assert.svh.
`timescale 1ns / 1ps
`include "text_command_line_parser_assert.svh"

module tclp_checker
  import tclp_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata,
  input logic             out_tlast
);

  `TCLP_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled item changed")
  `TCLP_ASSERT_SAME(a_ready, 1'b1, in_tready == (!out_tvalid || out_tready), "input ready does not follow output space")
  `TCLP_ASSERT_NEXT(a_item_out, in_tvalid && in_tready, out_tvalid, "accepted byte gave no item")
  `TCLP_ASSERT_SAME(a_code_line, out_tvalid && !out_tlast, out_tdata[OUT_CODE_LSB +: CODE_W] == CMD_NONE, "command outside a line end")
  `TCLP_ASSERT_NEXT(a_shut_sticky, out_tvalid && out_tdata[OUT_SHUT_BIT], !out_tvalid || out_tdata[OUT_SHUT_BIT], "shut-down flag cleared")

endmodule

bind text_command_line_parser tclp_checker u_tclp_checker (.*);
